// File: sv/gblur_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and kernel weights of the Gaussian blur block.
// Depends on nothing; every other file of the block imports it.
package gblur_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 2048;
   localparam int unsigned DEF_LINES_KEPT = 4;

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned ROW_W    = 12;
   localparam int unsigned COL_W    = 11;
   localparam int unsigned CSR_W    = 12;
   localparam int unsigned CSR_IX_W = 2;
   localparam int unsigned ROWSUM_W = 13;   // one weighted row: at most 26 * 255
   localparam int unsigned SUM_W    = 15;   // whole window: at most 84 * 255

   localparam int unsigned FIFO_DEPTH = 8;

   localparam logic              RST_KERNEL_MODE  = 1'b1;
   localparam logic [CSR_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
   localparam logic [CSR_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;

   // Division by 84: drop two bits, then multiply by ceil(2^21 / 21) and shift.
   // Exact for every quarter sum below 2^21 / 13.
   localparam int unsigned DIV_SHIFT = 21;
   localparam int unsigned MUL_W     = 30;
   localparam logic [16:0] DIV_MULT  = 17'd99865;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_KERNEL_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_3X3 = 1'b0,
      MODE_5X5 = 1'b1
   } kernel_mode_type;

   typedef logic [4:0][4:0][PIX_W-1:0] window_type;

   typedef struct packed {
      kernel_mode_type   mode;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              frame_end;
   } tag_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_out;
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  out_col;
      logic              frame_end;
   } rsp_type;

   localparam logic [3:0] K5 [5][5] = '{
      '{1, 2, 3, 2, 1},
      '{2, 5, 6, 5, 2},
      '{3, 6, 8, 6, 3},
      '{2, 5, 6, 5, 2},
      '{1, 2, 3, 2, 1}
   };

   // 1-2-1 kernel placed in the lower right corner of the 5x5 window
   localparam logic [3:0] K3 [5][5] = '{
      '{0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0},
      '{0, 0, 1, 2, 1},
      '{0, 0, 2, 4, 2},
      '{0, 0, 1, 2, 1}
   };

endpackage

// File: sv/gblur_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for source pixels and blurred results.
// Depends on gblur_pkg for the field widths.
interface gblur_req_if import gblur_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gblur_rsp_if import gblur_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  pixel_out;
   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic              frame_end;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input frame_end, output ready);
endinterface

// File: sv/gaussian_blur_3x3_or_5x5_top.sv
`timescale 1ns / 1ps
// Top level of the streaming Gaussian blur: registers, counters, credit, wiring.
// Depends on gblur_pkg, gblur_stream_if, gblur_window, gblur_filter, gblur_out_fifo.
//
// Usage:
//   req_stream carries 8-bit grey pixels in raster order; a transaction is one
//   pixel. rsp_stream carries one blurred pixel with its row, column and an
//   end-of-frame flag for every interior pixel; border pixels give nothing.
//   The csr_ port writes kernel_mode (index 0), image_width (1) and
//   image_height (2) at any edge with csr_write_enable high; write only while
//   no pixel is in flight. Other indexes are dropped.
// Throughput: one pixel per clock while ready is high. The line store takes one
//   read and one write each cycle (read at acceptance, shifted column written
//   back in the next cycle, same-column overlap forwarded), which sets that rate.
// Pipeline: an accepted pixel passes the line store read, the window, the row
//   sums and the window sum with divide into the queue, whose head is offered
//   on rsp_stream.
// Reset: registers return to mode 5x5, 640 x 480; counters and window clear.
//   The line store is not cleared; its stale words only reach border windows.
// Stall: up to eight results queue while rsp_stream is held off; req_stream
//   ready drops once eight results are owed and rises as they are taken.
module gaussian_blur_3x3_or_5x5_top import gblur_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int unsigned LINES_KEPT = DEF_LINES_KEPT
) (
   input  logic                 clock,
   input  logic                 reset,
   gblur_req_if.sink            req_stream,
   gblur_rsp_if.source          rsp_stream,
   input  logic                 csr_write_enable,
   input  logic [CSR_IX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   localparam int unsigned AW    = $clog2(MAX_WIDTH);
   localparam int unsigned CMP_W = (AW + 1 > CSR_W) ? AW + 1 : CSR_W;
   localparam int unsigned OUT_W = $clog2(FIFO_DEPTH + 1);

   // configuration registers
   kernel_mode_type     mode_ff;
   logic [CSR_W-1:0]    width_ff;
   logic [CSR_W-1:0]    height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= kernel_mode_type'(RST_KERNEL_MODE);
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KERNEL_MODE:  mode_ff   <= kernel_mode_type'(csr_write_data[0]);
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // frame position counters
   logic [AW-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CMP_W-1:0]    w_eff;
   logic [ROW_W-1:0]    h_eff;
   logic [AW-1:0]       cur_col;
   logic [ROW_W-1:0]    cur_row;
   logic [ROW_W:0]      row_bump;
   logic [ROW_W:0]      row_next;
   logic [AW:0]         col_next;
   logic                take;
   logic                result;
   tag_type             tag;
   logic [AW-1:0]       ocol_full;

   always_comb begin
      // clamp width to 1..MAX_WIDTH, height to at least 1
      w_eff = CMP_W'(width_ff);
      if (width_ff == '0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end
      h_eff = (height_ff == '0) ? ROW_W'(1) : height_ff;

      // end a line left open by a narrowed width, wrap a row beyond the height
      if (CMP_W'(col_ff) >= w_eff) begin
         cur_col  = '0;
         row_bump = {1'b0, row_ff} + 1'b1;
      end else begin
         cur_col  = col_ff;
         row_bump = {1'b0, row_ff};
      end
      cur_row = (row_bump >= {1'b0, h_eff}) ? '0 : row_bump[ROW_W-1:0];

      // advance past this pixel
      col_next = {1'b0, cur_col} + 1'b1;
      row_next = {1'b0, cur_row} + 1'b1;
      if (CMP_W'(col_next) >= w_eff) begin
         col_in = '0;
         row_in = (row_next >= {1'b0, h_eff}) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_in = col_next[AW-1:0];
         row_in = cur_row;
      end
   end

   always_comb begin
      tag.mode = mode_ff;
      if (mode_ff == MODE_5X5) begin
         result    = (LINES_KEPT >= 4) && (cur_row >= ROW_W'(4)) && (cur_col >= AW'(4));
         tag.row   = cur_row - ROW_W'(2);
         ocol_full = cur_col - AW'(2);
      end else begin
         result    = (cur_row >= ROW_W'(2)) && (cur_col >= AW'(2));
         tag.row   = cur_row - ROW_W'(1);
         ocol_full = cur_col - AW'(1);
      end
      tag.col       = COL_W'(ocol_full);
      tag.frame_end = (cur_row == h_eff - 1'b1) && (CMP_W'(cur_col) == w_eff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // credit: results accepted but not yet taken, bounded by the queue depth
   logic [OUT_W-1:0]   outstanding_ff, outstanding_in;
   logic               pop;
   logic [OUT_W-1:0]   fifo_level;

   assign req_stream.ready = (outstanding_ff < OUT_W'(FIFO_DEPTH));
   assign take             = req_stream.valid && req_stream.ready;
   assign pop              = rsp_stream.valid && rsp_stream.ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if ((take && result) && !pop) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (pop && !(take && result)) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // datapath
   window_type  window;
   logic        win_valid;
   tag_type     win_tag;
   logic        flt_valid;
   rsp_type     flt_data;
   logic        head_valid;
   rsp_type     head_data;

   gblur_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .LINES_KEPT (LINES_KEPT)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .column    (cur_col),
      .pixel     (req_stream.pixel_in),
      .result    (result),
      .tag       (tag),
      .window    (window),
      .win_valid (win_valid),
      .win_tag   (win_tag)
   );

   gblur_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .window    (window),
      .tag       (win_tag),
      .out_valid (flt_valid),
      .out_data  (flt_data)
   );

   gblur_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (flt_valid),
      .push_data  (flt_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .level      (fifo_level)
   );

   assign rsp_stream.valid     = head_valid;
   assign rsp_stream.pixel_out = head_data.pixel_out;
   assign rsp_stream.out_row   = head_data.out_row;
   assign rsp_stream.out_col   = head_data.out_col;
   assign rsp_stream.frame_end = head_data.frame_end;

   // checks
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OUT_W'(FIFO_DEPTH))
      else $error("more results owed than the queue can hold");

   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_level <= outstanding_ff)
      else $error("result queue holds more entries than were accepted");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_stream.valid)
      else $error("result offered straight after reset");

endmodule

// File: sv/gblur_window.sv
`timescale 1ns / 1ps
// Line store memory (one word per column, all kept lines side by side) and the
// 5x5 window registers. Depends on gblur_pkg.
module gblur_window import gblur_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int unsigned LINES_KEPT = DEF_LINES_KEPT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [$clog2(MAX_WIDTH)-1:0]  column,
   input  logic [PIX_W-1:0]              pixel,
   input  logic                          result,
   input  tag_type                       tag,
   output window_type                    window,
   output logic                          win_valid,
   output tag_type                       win_tag
);

   localparam int unsigned AW     = $clog2(MAX_WIDTH);
   localparam int unsigned WORD_W = LINES_KEPT * PIX_W;

   logic [WORD_W-1:0] line_mem [MAX_WIDTH];

   logic [WORD_W-1:0] rd_data_ff;
   logic              s1_valid_ff;
   logic [AW-1:0]     s1_col_ff;
   logic [PIX_W-1:0]  s1_pixel_ff;
   logic              s1_result_ff;
   tag_type           s1_tag_ff;
   logic              fwd_ff;
   logic [WORD_W-1:0] fwd_data_ff;
   logic              fwd_in;

   logic [WORD_W-1:0]          old_slots;
   logic [WORD_W-1:0]          wr_data;
   logic [4:0][PIX_W-1:0]      new_col;

   window_type window_ff;
   logic       win_valid_ff;
   tag_type    win_tag_ff;

   // read at acceptance, write back the shifted column in the next cycle
   always_ff @(posedge clock) begin
      if (take) begin
         rd_data_ff <= line_mem[column];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
      end
   end

   // the same column read while it is being written: take the new word
   assign fwd_in = take && s1_valid_ff && (s1_col_ff == column);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= take;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
      if (take) begin
         s1_col_ff    <= column;
         s1_pixel_ff  <= pixel;
         s1_result_ff <= result;
         s1_tag_ff    <= tag;
      end
   end

   assign old_slots = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_data   = {old_slots[(LINES_KEPT-1)*PIX_W-1:0], s1_pixel_ff};

   for (genvar k = 0; k < 4; k++) begin : g_tap
      if (k < LINES_KEPT) begin : g_kept
         assign new_col[3-k] = old_slots[k*PIX_W +: PIX_W];
      end else begin : g_zero
         assign new_col[3-k] = '0;
      end
   end
   assign new_col[4] = s1_pixel_ff;

   // shift the window left and load the fresh column on the right
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         win_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= s1_valid_ff && s1_result_ff;
         if (s1_valid_ff) begin
            for (int i = 0; i < 5; i++) begin
               for (int j = 0; j < 4; j++) begin
                  window_ff[i][j] <= window_ff[i][j+1];
               end
               window_ff[i][4] <= new_col[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_tag_ff <= s1_tag_ff;
      end
   end

   assign window    = window_ff;
   assign win_valid = win_valid_ff;
   assign win_tag   = win_tag_ff;

endmodule

// File: sv/gblur_filter.sv
`timescale 1ns / 1ps
// Kernel arithmetic: weighted row sums, window sum, then shift or divide by 84.
// Depends on gblur_pkg.
module gblur_filter import gblur_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  window_type  window,
   input  tag_type     tag,
   output logic        out_valid,
   output rsp_type     out_data
);

   logic [4:0][ROWSUM_W-1:0] rows_in;
   logic [4:0][ROWSUM_W-1:0] rows_ff;
   logic                     a_valid_ff;
   tag_type                  a_tag_ff;

   logic [SUM_W-1:0]         total_ff;
   logic                     b_valid_ff;
   tag_type                  b_tag_ff;

   logic [MUL_W-1:0]         prod;
   logic [PIX_W-1:0]         quot5;
   logic [PIX_W-1:0]         quot3;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         rows_in[i] = '0;
         for (int j = 0; j < 5; j++) begin
            if (tag.mode == MODE_5X5) begin
               rows_in[i] = rows_in[i] + ROWSUM_W'(K5[i][j]) * ROWSUM_W'(window[i][j]);
            end else if (i >= 2 && j >= 2) begin
               // 3x3 taps only; rows and columns outside the kernel stay out of the sum
               rows_in[i] = rows_in[i] + ROWSUM_W'(K3[i][j]) * ROWSUM_W'(window[i][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff  <= rows_in;
      a_tag_ff <= tag;
      b_tag_ff <= a_tag_ff;
   end

   // sum of the registered row sums
   always_ff @(posedge clock) begin
      total_ff <= SUM_W'(rows_ff[0]) + SUM_W'(rows_ff[1]) + SUM_W'(rows_ff[2])
                + SUM_W'(rows_ff[3]) + SUM_W'(rows_ff[4]);
   end

   assign prod  = MUL_W'(DIV_MULT) * MUL_W'(total_ff[SUM_W-1:2]);
   assign quot5 = prod[DIV_SHIFT +: PIX_W];
   assign quot3 = total_ff[4 +: PIX_W];

   assign out_valid          = b_valid_ff;
   assign out_data.pixel_out = (b_tag_ff.mode == MODE_5X5) ? quot5 : quot3;
   assign out_data.out_row   = b_tag_ff.row;
   assign out_data.out_col   = b_tag_ff.col;
   assign out_data.frame_end = b_tag_ff.frame_end;

endmodule

// File: sv/gblur_out_fifo.sv
`timescale 1ns / 1ps
// Result queue between the arithmetic pipeline and the result channel.
// Depends on gblur_pkg.
module gblur_out_fifo import gblur_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  rsp_type                           push_data,
   input  logic                              pop,
   output logic                              head_valid,
   output rsp_type                           head_data,
   output logic [$clog2(FIFO_DEPTH+1)-1:0]   level
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

   rsp_type             entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]    level_ff,  level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule
